FILE: design/bbsc_pkg.sv
package bbsc_pkg;

  localparam int MAX_LEN_DEFAULT = 1024;
  localparam int COUNT_W = 20;
  localparam logic [7:0] ZERO_CHAR = 8'd48;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Control that travels with one item from the address stage to the histogram stage.
  typedef struct packed {
    logic valid;
    logic active;    // the item falls within the first MAX_LEN characters
    logic hit;       // the histogram entry was already written in this string
    logic at_zero;   // the new prefix difference is zero
    logic last;
    logic too_long;
  } hist_req_t;

endpackage

FILE: design/bbsc_if.sv
interface bbsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source(output valid, symbol, last, input ready);
  modport sink(input valid, symbol, last, output ready);
endinterface

interface bbsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [bbsc_pkg::COUNT_W-1:0] balanced_count;
  logic                         too_long;

  modport source(output valid, balanced_count, too_long, input ready);
  modport sink(input valid, balanced_count, too_long, output ready);
endinterface

FILE: design/bbsc_front.sv
module bbsc_front #(
  parameter int MAX_LEN = bbsc_pkg::MAX_LEN_DEFAULT,
  parameter int DIFF_W  = $clog2(MAX_LEN + 1) + 1,
  parameter int ADDR_W  = $clog2(2 * MAX_LEN + 1),
  parameter int LEN_W   = $clog2(MAX_LEN + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          symbol,
  input  logic                last,
  output bbsc_pkg::hist_req_t req,
  output logic [ADDR_W-1:0]   addr
);
  import bbsc_pkg::*;

  localparam logic signed [ADDR_W:0] OFFSET = (ADDR_W + 1)'(MAX_LEN);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN);

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] diff_next;
  logic signed [DIFF_W-1:0] lo;
  logic signed [DIFF_W-1:0] hi;
  logic                     seen_any;
  logic [LEN_W-1:0]         length_seen;
  logic                     overflow_seen;
  logic                     room;
  logic                     hit;
  logic signed [ADDR_W:0]   addr_wide;

  // The difference moves by one per character, so every value between the lowest and
  // highest seen in this string has been visited: exactly those entries are current.
  always_comb begin
    room      = length_seen < LEN_LIMIT;
    diff_next = (symbol == ZERO_CHAR) ? diff - DIFF_W'(1) : diff + DIFF_W'(1);
    hit       = seen_any && (diff_next >= lo) && (diff_next <= hi);
    addr_wide = (ADDR_W + 1)'(diff_next) + OFFSET;
    addr      = addr_wide[ADDR_W-1:0];

    req.valid    = accept;
    req.active   = room;
    req.hit      = hit;
    req.at_zero  = (diff_next == '0);
    req.last     = last;
    req.too_long = overflow_seen || !room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff          <= '0;
      lo            <= '0;
      hi            <= '0;
      seen_any      <= 1'b0;
      length_seen   <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (last) begin
        diff          <= '0;
        seen_any      <= 1'b0;
        length_seen   <= '0;
        overflow_seen <= 1'b0;
      end else if (room) begin
        diff        <= diff_next;
        length_seen <= length_seen + LEN_W'(1);
        seen_any    <= 1'b1;
        if (!seen_any || diff_next < lo) begin
          lo <= diff_next;
        end
        if (!seen_any || diff_next > hi) begin
          hi <= diff_next;
        end
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

endmodule

FILE: design/bbsc_hist.sv
module bbsc_hist #(
  parameter int MAX_LEN = bbsc_pkg::MAX_LEN_DEFAULT,
  parameter int ADDR_W  = $clog2(2 * MAX_LEN + 1),
  parameter int CNT_W   = $clog2(MAX_LEN + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  bbsc_pkg::hist_req_t req,
  input  logic [ADDR_W-1:0]   addr,
  output logic                stall,
  bbsc_out_if.source          results
);
  import bbsc_pkg::*;

  localparam int DEPTH = 2 * MAX_LEN + 1;
  localparam int SUM_W = COUNT_W + 1;

  logic [CNT_W-1:0]   mem [DEPTH];
  logic [CNT_W-1:0]   rdata;
  hist_req_t          s1;
  logic [ADDR_W-1:0]  s1_addr;
  logic [COUNT_W-1:0] total;
  logic [CNT_W-1:0]   hist_val;
  logic [CNT_W:0]     add;
  logic [SUM_W-1:0]   sum;
  logic [COUNT_W-1:0] total_sat;
  logic               advance;
  logic               wr_en;
  logic [CNT_W-1:0]   wr_data;
  logic               out_valid;
  logic [COUNT_W-1:0] out_count;
  logic               out_too_long;

  // Within a string, consecutive items address neighboring entries, so the write of one item
  // never meets the read of the next at one address; a new string's first read is not used.
  always_comb begin
    stall     = s1.valid && s1.last && out_valid && !results.ready;
    advance   = s1.valid && !stall;
    hist_val  = s1.hit ? rdata : '0;
    add       = {1'b0, hist_val} + (CNT_W + 1)'(s1.at_zero);
    sum       = SUM_W'(total) + SUM_W'(add);
    total_sat = sum[SUM_W-1] ? COUNT_MAX : sum[COUNT_W-1:0];
    wr_en     = advance && s1.active;
    wr_data   = hist_val + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.active) begin
      rdata <= mem[addr];
    end
    if (wr_en) begin
      mem[s1_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      total    <= '0;
    end else begin
      if (!stall) begin
        s1 <= req;
      end
      if (advance) begin
        if (s1.last) begin
          total <= '0;
        end else if (s1.active) begin
          total <= total_sat;
        end
      end
    end
    if (!stall) begin
      s1_addr <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1.last) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && s1.last) begin
      out_count    <= s1.active ? total_sat : total;
      out_too_long <= s1.too_long;
    end
  end

  assign results.valid          = out_valid;
  assign results.balanced_count = out_count;
  assign results.too_long       = out_too_long;

endmodule

FILE: design/balanced_binary_substring_counter_core.sv
// A result enters the output register when its last character leaves stage s1.
// Throughput: one character per cycle unless stalled, set by one histogram read-modify-write
// per character in a single-port-write, one-read memory of 2*MAX_LEN+1 counters.
// Input ready drops only while a finished total waits for an output register still held.
// Reset clears all control state; the histogram needs no clearing pass, since entries
// outside the range of differences visited in the current string read as zero.
module balanced_binary_substring_counter_core #(
  parameter int MAX_LEN = bbsc_pkg::MAX_LEN_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  bbsc_in_if.sink    symbols,
  bbsc_out_if.source results
);
  import bbsc_pkg::*;

  localparam int DIFF_W = $clog2(MAX_LEN + 1) + 1;
  localparam int ADDR_W = $clog2(2 * MAX_LEN + 1);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);

  hist_req_t         req;
  logic [ADDR_W-1:0] addr;
  logic              stall;
  logic              accept;

  assign symbols.ready = !stall;
  assign accept        = symbols.valid && !stall;

  bbsc_front #(
    .MAX_LEN(MAX_LEN),
    .DIFF_W (DIFF_W),
    .ADDR_W (ADDR_W),
    .LEN_W  (LEN_W)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .symbol(symbols.symbol),
    .last  (symbols.last),
    .req   (req),
    .addr  (addr)
  );

  bbsc_hist #(
    .MAX_LEN(MAX_LEN),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_hist (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .addr   (addr),
    .stall  (stall),
    .results(results)
  );

endmodule

FILE: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bbsc_pkg::*;

  localparam int STR_MAX = MAX_LEN_DEFAULT;
  localparam int HIST_SIZE = 2 * STR_MAX + 1;
  localparam int MAX_GAP = 60;
  localparam int RANDOM_ITEMS = 500;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               too_long;
  } string_total_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbsc_in_if  symbols_bus();
  bbsc_out_if results_bus();

  balanced_binary_substring_counter_core #(.MAX_LEN(STR_MAX)) dut (
    .clk(clk),
    .rst(rst),
    .symbols(symbols_bus),
    .results(results_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  char_item_t    pending_chars[$];
  string_total_t expected_totals[$];

  // Shadow copy of the string state.
  int            prefix_counts[HIST_SIZE];
  int            prefix_diff;
  int            chars_seen;
  logic [COUNT_W-1:0] pair_total;
  logic          overflowed;

  int  error_count = 0;
  int  cycle_count = 0;
  int  cycle_limit = 2000000;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  item_taken = 0;
  bit  calm = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic clear_string();
    prefix_diff = 0;
    chars_seen = 0;
    pair_total = '0;
    overflowed = 1'b0;
    foreach (prefix_counts[i]) prefix_counts[i] = 0;
  endtask

  task automatic count_balanced(input logic [7:0] sym, input logic is_last);
    longint sum;
    int     idx;
    string_total_t t;
    if (chars_seen < STR_MAX) begin
      prefix_diff += (sym == ZERO_CHAR) ? -1 : 1;
      chars_seen++;
      idx = prefix_diff + STR_MAX;
      sum = longint'(pair_total) + prefix_counts[idx] + ((prefix_diff == 0) ? 1 : 0);
      if (sum > longint'(COUNT_MAX)) sum = longint'(COUNT_MAX);
      pair_total = sum[COUNT_W-1:0];
      prefix_counts[idx]++;
    end else begin
      // Characters past the length limit only mark the string as too long.
      overflowed = 1'b1;
    end
    if (is_last) begin
      t.count = pair_total;
      t.too_long = overflowed;
      expected_totals.push_back(t);
      clear_string();
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, MAX_GAP);
  endfunction

  task automatic add_char(input logic [7:0] sym, input logic is_last);
    char_item_t c;
    c.symbol = sym;
    c.last = is_last;
    pending_chars.push_back(c);
  endtask

  // Mostly '0' and '1', now and then any byte.
  function automatic logic [7:0] random_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return ZERO_CHAR;
    if (r < 90) return 8'd49;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_long_string(input int len, input int mode);
    logic [7:0] s;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: begin
          s = (i % 2 == 0) ? ZERO_CHAR : 8'd49;
        end
        1: begin
          s = 8'hFF;
        end
        default: begin
          s = random_symbol();
        end
      endcase
      add_char(s, i == len - 1);
    end
  endtask

  // Input side: present items, with random gaps after each one.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (!rst && symbols_bus.valid && symbols_bus.ready) begin
      count_balanced(symbols_bus.symbol, symbols_bus.last);
      item_taken = 1;
    end
  end

  always @(negedge clk) begin
    char_item_t c;
    if (!rst && (!symbols_bus.valid || item_taken)) begin
      item_taken = 0;
      if (gap_left > 0) begin
        symbols_bus.valid <= 1'b0;
        gap_left--;
      end else if (pending_chars.size() > 0) begin
        c = pending_chars.pop_front();
        symbols_bus.symbol <= c.symbol;
        symbols_bus.last <= c.last;
        symbols_bus.valid <= 1'b1;
        gap_left = gap_len();
      end else begin
        symbols_bus.valid <= 1'b0;
      end
    end
  end

  // Output side: stalls start at random, independent of the handshake.
  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 299) == 0) calm = !calm;
      if (stall_left > 0) begin
        results_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        results_bus.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    string_total_t want;
    if (!rst && results_bus.valid && results_bus.ready) begin
      if (expected_totals.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0d too_long=%0b",
                                  results_bus.balanced_count, results_bus.too_long));
      end else begin
        want = expected_totals.pop_front();
        if (results_bus.balanced_count !== want.count)
          report_mismatch($sformatf("balanced_count %0d, expected %0d",
                                    results_bus.balanced_count, want.count));
        if (results_bus.too_long !== want.too_long)
          report_mismatch($sformatf("too_long %0b, expected %0b",
                                    results_bus.too_long, want.too_long));
      end
    end
  end

  initial begin
    int n_strings;
    int random_chars;
    int len;
    symbols_bus.valid = 1'b0;
    symbols_bus.symbol = '0;
    symbols_bus.last = 1'b0;
    results_bus.ready = 1'b0;
    clear_string();

    // Single-character strings at the byte extremes and at the zero character.
    add_char(ZERO_CHAR, 1'b1);
    add_char(8'h00, 1'b1);
    add_char(8'hFF, 1'b1);
    // Neighbors of the zero character count as ones.
    add_char(8'd47, 1'b0);
    add_char(ZERO_CHAR, 1'b1);
    add_char(ZERO_CHAR, 1'b0);
    add_char(8'd49, 1'b1);
    add_char(ZERO_CHAR, 1'b0);
    add_char(ZERO_CHAR, 1'b0);
    add_char(8'd49, 1'b0);
    add_char(ZERO_CHAR, 1'b0);
    add_char(8'd49, 1'b0);
    add_char(8'd49, 1'b1);
    add_char(8'hAA, 1'b0);
    add_char(8'h55, 1'b0);
    add_char(ZERO_CHAR, 1'b0);
    add_char(ZERO_CHAR, 1'b1);
    n_strings = 7;

    random_chars = 0;
    while (random_chars < RANDOM_ITEMS) begin
      // A few strings reach the length limit: exactly at it, just past it, and around it.
      if (n_strings == 15) add_long_string(STR_MAX, 0);
      else if (n_strings == 30) add_long_string(STR_MAX + 1, 1);
      else if (n_strings == 45) add_long_string($urandom_range(STR_MAX - 2, STR_MAX + 40), 2);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) add_char(random_symbol(), i == len - 1);
      random_chars += len;
      n_strings++;
    end

    cycle_limit = 3 * (pending_chars.size() * (MAX_GAP + 2) + n_strings * (MAX_GAP + 4))
                  + 5000;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_chars.size() > 0 || symbols_bus.valid) @(posedge clk);
    while (expected_totals.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/bbsc_pkg.sv
design/bbsc_if.sv
design/bbsc_front.sv
design/bbsc_hist.sv
design/balanced_binary_substring_counter_core.sv
test/testbench.sv
